/* hw/rtl/block_then_moving_average_defines.svh */
// Assertion macros shared by the block-average checkers.
`ifndef BLOCK_THEN_MOVING_AVERAGE_DEFINES_SVH
`define BLOCK_THEN_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define BTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bta_pkg.sv */
// Shared constants for the block-then-moving-average filter.
`default_nettype none

package bta_pkg;

  // Fixed port widths of the sample and average beats.
  localparam int ADC_W = 16;
  localparam int AVG_W = 16;

endpackage

`default_nettype wire

/* hw/rtl/bta_cell.sv */
// One history cell: holds a block average and hands it on when the chain shifts.
`default_nettype none

module bta_cell #(
  parameter int ENTRY_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic [ENTRY_W-1:0] d_in,
  output logic [ENTRY_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bta_accum.sv */
// Block accumulator: sums one round of samples and flags the commit tick.
`default_nettype none

module bta_accum #(
  parameter int BLOCK_LOG2 = 2,
  parameter int ENTRY_W    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [ENTRY_W-1:0] sample,
  output logic               commit,
  output logic [ENTRY_W-1:0] fresh
);

  localparam int SUM_W   = ENTRY_W + BLOCK_LOG2;
  localparam int CNT_W   = BLOCK_LOG2 + 1;
  localparam int BLOCK_N = 1 << BLOCK_LOG2;

  logic [SUM_W-1:0] block_sum;
  logic [CNT_W-1:0] sample_count;

  // Count never passes BLOCK_N, so equality marks the commit tick.
  assign commit = (sample_count == CNT_W'(BLOCK_N));
  assign fresh  = block_sum[SUM_W-1:BLOCK_LOG2];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum    <= '0;
      sample_count <= '0;
    end else if (en) begin
      if (commit) begin
        block_sum    <= '0;
        sample_count <= '0;
      end else begin
        block_sum    <= block_sum + SUM_W'(sample);
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/block_then_moving_average.sv */
// Block average followed by a moving average over a chain of history cells.
// Each input beat is one sample tick. A round is 2^BLOCK_LOG2 sample ticks
// that add their masked sample into a block sum, then one commit tick whose
// sample is ignored. The commit tick pushes block_sum >> BLOCK_LOG2 into the
// head of a chain of 2^HISTORY_LOG2 cells; the oldest entry drops off the
// tail, and the running total is corrected by (fresh - oldest) in one step.
// Every input beat yields exactly one output beat carrying the current
// average (running total >> HISTORY_LOG2, held between commits) and a
// committed flag. One beat per clock unless the output stalls; the result is
// registered, ready the cycle after its sample is taken, and the input stalls
// while a finished result waits downstream. All history cells clear on reset,
// so the average ramps up from zero over the first 2^HISTORY_LOG2 commits and
// no clearing pass is needed. Input bits above SAMPLE_BITS are dropped.
`default_nettype none

module block_then_moving_average
  import bta_pkg::*;
#(
  parameter int BLOCK_LOG2   = 2,
  parameter int HISTORY_LOG2 = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  // sample channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ADC_W-1:0] adc_sample,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [AVG_W-1:0] average,
  output logic             committed
);

  // Entry width: samples are masked to SAMPLE_BITS but never exceed the port.
  localparam int ENTRY_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
  localparam int TOTAL_W = ENTRY_W + HISTORY_LOG2;
  localparam int DEPTH   = 1 << HISTORY_LOG2;

  logic               in_accept;
  logic               commit;
  logic               shift;
  logic [ENTRY_W-1:0] sample;
  logic [ENTRY_W-1:0] fresh;
  logic [ENTRY_W-1:0] hist_q [DEPTH];
  logic [TOTAL_W-1:0] running_total;
  logic [TOTAL_W-1:0] running_total_next;

  // Output register empties or drains this cycle -> room for a new beat.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign shift     = in_accept && commit;
  assign sample    = ENTRY_W'(adc_sample);

  bta_accum #(
    .BLOCK_LOG2 (BLOCK_LOG2),
    .ENTRY_W    (ENTRY_W)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .en     (in_accept),
    .sample (sample),
    .commit (commit),
    .fresh  (fresh)
  );

  // History chain: newest at cell 0, oldest at the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      bta_cell #(.ENTRY_W(ENTRY_W)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d_in  (fresh),
        .q     (hist_q[i])
      );
    end else begin : g_body
      bta_cell #(.ENTRY_W(ENTRY_W)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d_in  (hist_q[i-1]),
        .q     (hist_q[i])
      );
    end
  end

  // Total always equals the sum of the chain, so it cannot overflow.
  assign running_total_next = running_total - TOTAL_W'(hist_q[DEPTH-1])
                            + TOTAL_W'(fresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (shift) begin
      running_total <= running_total_next;
    end
  end

  // Output register; average doubles as the held current average.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      average   <= '0;
      committed <= 1'b0;
    end else begin
      if (in_accept) begin
        out_valid <= 1'b1;
        committed <= commit;
        if (commit) begin
          average <= AVG_W'(running_total_next[TOTAL_W-1:HISTORY_LOG2]);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bta_checker.sv */
// Port-level checker for the block-then-moving-average filter, with its bind.
`default_nettype none

`include "block_then_moving_average_defines.svh"

module bta_checker
  import bta_pkg::*;
#(
  parameter int BLOCK_LOG2 = 2
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [AVG_W-1:0] average,
  input logic             committed
);

  localparam int CNT_W   = BLOCK_LOG2 + 1;
  localparam int BLOCK_N = 1 << BLOCK_LOG2;

  logic             out_accept;
  logic [CNT_W-1:0] beat_count;
  logic [AVG_W-1:0] last_avg;

  assign out_accept = out_valid && !out_stall;

  // Beats since the last commit, and the average of the last beat delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_count <= '0;
      last_avg   <= '0;
    end else if (out_accept) begin
      beat_count <= committed ? '0 : beat_count + CNT_W'(1);
      last_avg   <= average;
    end
  end

  `BTA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(average) && $stable(committed),
    "result beat changed while stalled")
  `BTA_ASSERT_NOW(a_commit_spacing, out_valid,
    committed == (beat_count == CNT_W'(BLOCK_N)),
    "commit flag out of round position")
  `BTA_ASSERT_NOW(a_avg_held, out_valid && !committed, average == last_avg,
    "average moved on a non-commit beat")
  `BTA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled with room in output register")
  `BTA_ASSERT_NEXT(a_in_to_out, in_valid && !in_stall, out_valid,
    "accepted sample produced no result beat")

endmodule

bind block_then_moving_average bta_checker #(
  .BLOCK_LOG2 (BLOCK_LOG2)
) u_bta_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .average    (average),
  .committed  (committed)
);

`default_nettype wire

/* dv/tb_block_then_moving_average.sv */
// Self-checking testbench for the block average followed by the sixteen-tap moving average.

typedef struct packed {
  logic [bta_pkg::AVG_W-1:0] avg;
  logic                      committed;
} avg_beat_t;

class average_tracker;
  localparam int BLOCK_LOG2   = 2;
  localparam int HISTORY_LOG2 = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int BLOCK_SIZE   = 1 << BLOCK_LOG2;
  localparam int HIST_DEPTH   = 1 << HISTORY_LOG2;
  localparam logic [bta_pkg::ADC_W-1:0] SAMPLE_MASK = 16'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [SAMPLE_BITS+BLOCK_LOG2-1:0]   blk_sum;
  logic [2:0]                          taken;
  logic [SAMPLE_BITS-1:0]              ring[HIST_DEPTH];
  logic [HISTORY_LOG2-1:0]             slot;
  logic [SAMPLE_BITS+HISTORY_LOG2-1:0] total;
  logic [bta_pkg::AVG_W-1:0]           avg_now;

  avg_beat_t averages_due[$];
  int        mismatches;
  int        samples_seen;
  int        results_checked;
  int        commits_seen;
  logic [bta_pkg::AVG_W-1:0] peak_avg;

  function new();
    blk_sum = '0;
    taken   = '0;
    slot    = '0;
    total   = '0;
    avg_now = '0;
    foreach (ring[i]) ring[i] = '0;
    mismatches      = 0;
    samples_seen    = 0;
    results_checked = 0;
    commits_seen    = 0;
    peak_avg        = '0;
  endfunction

  // One accepted sample beat: advance the filter state, queue the result.
  function void note_sample(logic [bta_pkg::ADC_W-1:0] s);
    logic [bta_pkg::ADC_W-1:0] kept;
    logic [SAMPLE_BITS-1:0]    fresh;
    avg_beat_t                 b;
    kept = s & SAMPLE_MASK;
    samples_seen++;
    if (taken < BLOCK_SIZE) begin
      blk_sum += kept;
      taken++;
      b.committed = 1'b0;
    end else begin
      fresh     = blk_sum[SAMPLE_BITS+BLOCK_LOG2-1:BLOCK_LOG2];
      total     = total - ring[slot] + fresh;
      ring[slot] = fresh;
      avg_now   = total[SAMPLE_BITS+HISTORY_LOG2-1:HISTORY_LOG2];
      slot++;
      blk_sum   = '0;
      taken     = '0;
      b.committed = 1'b1;
      commits_seen++;
      if (avg_now > peak_avg) peak_avg = avg_now;
    end
    b.avg = avg_now;
    averages_due.push_back(b);
  endfunction

  function void check_result(logic [bta_pkg::AVG_W-1:0] a, logic c);
    avg_beat_t b;
    results_checked++;
    if (averages_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: result beat with nothing expected: average %h committed %b", a, c);
      return;
    end
    b = averages_due.pop_front();
    if (a !== b.avg || c !== b.committed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: mismatch on result %0d: average exp %h got %h, committed exp %b got %b",
                 results_checked, b.avg, a, b.committed, c);
    end
  endfunction

  function int pending();
    return averages_due.size();
  endfunction
endclass

module tb_block_then_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 64;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [bta_pkg::ADC_W-1:0] adc_sample = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic [bta_pkg::AVG_W-1:0] average;
  logic                      committed;

  // Idle odds in percent for each side; zeroed for the calm stretches.
  int tx_gap_pct   = 19;
  int rx_stall_pct = 19;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;

  average_tracker tracker = new();

  block_then_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .adc_sample(adc_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average),
    .committed (committed)
  );

  // 20 ns clock: 10 high, 10 low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (~2000 items).
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Both handshakes are sampled right at the edge, before any of this edge's
  // updates land, so the note comes ahead of the check for the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_sample(adc_sample);
      if (out_valid && !out_stall) tracker.check_result(average, committed);
    end
  end

  // Receiver: random stalls, or one long counted hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Mix of full-range values, rail values, tiny values and single set bits.
  function automatic logic [bta_pkg::ADC_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      6:       return '1;
      7:       return '0;
      8:       return 16'($urandom_range(0, 15));
      9:       return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample beat after idle cycles drawn one at a time, and hold it
  // until taken. Called right after an edge; returns right after the
  // accepting edge.
  task automatic send_tick(input logic [bta_pkg::ADC_W-1:0] v);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid   <= 1'b0;
      adc_sample <= 16'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait on the clock so the last accepted beat is surely noted,
  // then wait for every queued result to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rounds, each four samples plus a commit tick whose sample is
    // junk: warm-up from an all-zero ring, both rails, truncation of the
    // block shift, and alternating bit patterns.
    repeat (4) send_tick(16'hFFFF);
    send_tick(16'h1234);
    repeat (4) send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h0001);
    send_tick(16'h0002);
    send_tick(16'h0003);
    send_tick(16'h0004);
    send_tick(16'hA5A5);
    send_tick(16'hAAAA);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    send_tick(16'h5555);
    send_tick(16'h0000);

    // Broad random traffic with both sides idling.
    repeat (700) send_tick(pick_sample());

    // Back-to-back stretch: no gaps, no stalls.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (300) send_tick(pick_sample());
    tx_gap_pct   = 19;
    rx_stall_pct = 19;

    // Push the ring to full scale over more than a whole wrap, then back to
    // zero: average climbs to the top and ramps down again.
    repeat (85) send_tick(16'hFFFF);
    repeat (85) send_tick(16'h0000);

    // Long receiver hold-off while samples keep coming: the output register
    // fills and the block has to stall its input.
    tx_gap_pct   = 0;
    hold_request = 1'b1;
    repeat (40) send_tick(pick_sample());
    tx_gap_pct   = 19;

    // Sender pauses until everything in flight has come back.
    drain_results();
    @(posedge clk);

    repeat (570) send_tick(pick_sample());

    drain_results();
    repeat (8) @(posedge clk);

    $display("tb: %0d sample beats, %0d result beats, %0d commits, peak average %h",
             tracker.samples_seen, tracker.results_checked, tracker.commits_seen,
             tracker.peak_avg);
    $display("tb: covered warm-up, ring wrap, full-scale rails, gaps, stalls, long hold-off");
    if (tracker.mismatches > 10)
      $display("tb: %0d mismatches in total", tracker.mismatches);
    if (tracker.pending() != 0)
      $display("tb: %0d expected results never arrived", tracker.pending());

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
